>>> rtl/scgcd_pkg.sv
// Shared types, register indexes and digit decode for the shot clock and game clock display.
// No dependencies; every other file in the block imports this package.
`default_nettype none
package scgcd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_RELOAD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_RELOAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MINUTES = 2'd2;

  localparam logic [6:0] LONG_RELOAD_RST    = 7'd24;
  localparam logic [6:0] SHORT_RELOAD_RST   = 7'd14;
  localparam logic [6:0] PERIOD_MINUTES_RST = 7'd10;
  localparam logic [5:0] SECONDS_TOP        = 6'd59;
  localparam logic [6:0] DISPLAY_MAX        = 7'd99;

  // Clock state as seen by the display logic.
  typedef struct packed {
    logic [6:0] shot;
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic [1:0] phase;
    logic       expired;
  } clk_state_t;

  // One result item.
  typedef struct packed {
    logic [6:0] shot_segments;
    logic [1:0] shot_digit_enable;
    logic [6:0] game_segments;
    logic [3:0] game_digit_enable;
    logic       buzzer;
    logic [6:0] shot_value;
    logic [6:0] minutes_value;
    logic [5:0] seconds_value;
  } result_t;

  // Segment pattern gfedcba for a decimal digit.
  function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0: pat = 7'h3F;
      4'd1: pat = 7'h06;
      4'd2: pat = 7'h5B;
      4'd3: pat = 7'h4F;
      4'd4: pat = 7'h66;
      4'd5: pat = 7'h6D;
      4'd6: pat = 7'h7D;
      4'd7: pat = 7'h07;
      4'd8: pat = 7'h7F;
      4'd9: pat = 7'h6F;
      default: pat = 7'h3F;
    endcase
    return pat;
  endfunction

  // Pattern of the tens or ones digit of a value saturated at 99. The tens
  // digit comes from a multiply by 205 and a shift by 11, exact up to 159.
  function automatic logic [6:0] seg_of(input logic [6:0] value, input logic tens);
    logic [6:0]  sat;
    logic [14:0] prod;
    logic [3:0]  tens_d;
    logic [6:0]  ones_v;
    sat    = (value > DISPLAY_MAX) ? DISPLAY_MAX : value;
    prod   = {8'd0, sat} * 15'd205;
    tens_d = prod[14:11];
    ones_v = sat - {tens_d[3:0], 3'b000} - {2'b00, tens_d, 1'b0};
    return seg_pattern(tens ? tens_d : ones_v[3:0]);
  endfunction

endpackage
`default_nettype wire

>>> rtl/scgcd_core.sv
// Configuration registers and clock state with the per-item update rule.
// Depends on scgcd_pkg.
`default_nettype none
module scgcd_core import scgcd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  accept,
  input  wire logic                  kind,
  input  wire logic                  press_long,
  input  wire logic                  press_short,
  output clk_state_t                 st,
  output clk_state_t                 st_nxt
);

  logic [6:0] long_reload_r, short_reload_r;
  clk_state_t st_r;

  always_comb begin
    st_nxt = st_r;
    if (accept) begin
      if (kind) begin
        if (press_long) begin
          st_nxt.shot    = long_reload_r;
          st_nxt.expired = 1'b0;
        end else if (press_short) begin
          st_nxt.shot    = short_reload_r;
          st_nxt.expired = 1'b0;
        end else if (!st_r.expired) begin
          if (st_r.minutes == 7'd0 && st_r.seconds == 6'd0) begin
            st_nxt.expired = 1'b1;
          end else begin
            if (st_r.seconds == 6'd0) begin
              st_nxt.minutes = st_r.minutes - 7'd1;
              st_nxt.seconds = SECONDS_TOP;
            end else begin
              st_nxt.seconds = st_r.seconds - 6'd1;
            end
            if (st_r.shot == 7'd0) begin
              st_nxt.expired = 1'b1;
            end else begin
              st_nxt.shot = st_r.shot - 7'd1;
            end
          end
        end
      end else begin
        st_nxt.phase = st_r.phase + 2'd1;
      end
    end
    // The period register is not kept: a write only reloads the game clock.
    if (cfg_we && cfg_index == REG_PERIOD_MINUTES) begin
      st_nxt.minutes = cfg_wdata;
      st_nxt.seconds = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_reload_r  <= LONG_RELOAD_RST;
      short_reload_r <= SHORT_RELOAD_RST;
      st_r.shot      <= LONG_RELOAD_RST;
      st_r.minutes   <= PERIOD_MINUTES_RST;
      st_r.seconds   <= 6'd0;
      st_r.phase     <= 2'd0;
      st_r.expired   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_RELOAD:  long_reload_r  <= cfg_wdata;
          REG_SHORT_RELOAD: short_reload_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign st = st_r;

endmodule
`default_nettype wire

>>> rtl/scgcd_disp.sv
// Digit multiplexing and seven-segment decode for one result item.
// Depends on scgcd_pkg.
`default_nettype none
module scgcd_disp import scgcd_pkg::*; (
  input  wire clk_state_t st,
  output result_t         res
);

  logic tens;

  always_comb begin
    tens = ~st.phase[0];
    res.shot_segments     = seg_of(st.shot, tens);
    res.shot_digit_enable = tens ? 2'b10 : 2'b01;
    res.game_segments     = st.phase[1] ? seg_of({1'b0, st.seconds}, tens)
                                        : seg_of(st.minutes, tens);
    res.game_digit_enable = ~(4'b0001 << st.phase);
    res.buzzer            = st.expired;
    res.shot_value        = st.shot;
    res.minutes_value     = st.minutes;
    res.seconds_value     = st.seconds;
  end

endmodule
`default_nettype wire

>>> rtl/shot_clock_game_clock_display.sv
// Top level of the shot clock and game clock display: state, decode, result queue.
// Depends on scgcd_pkg, scgcd_core and scgcd_disp.
`default_nettype none
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_stall     in_kind, in_press_long, in_press_short
// out_      output     out_valid / out_stall   segments, digit enables, buzzer, values
// cfg_      input      cfg_we                  cfg_index, cfg_wdata
//
// Every accepted item yields one result item, registered into the result
// queue; one item per cycle is sustained while out_stall stays low.
// The result side has a two-entry queue, so an item is still taken while one
// finished result waits; in_stall rises only when both entries are full.
// Reset (rst_n low, synchronous) loads the shot clock with 24 and the game
// clock with 10:00 and empties the queue.
module shot_clock_game_clock_display import scgcd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_kind,
  input  wire logic                  in_press_long,
  input  wire logic                  in_press_short,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [6:0]                 out_shot_segments,
  output logic [1:0]                 out_shot_digit_enable,
  output logic [6:0]                 out_game_segments,
  output logic [3:0]                 out_game_digit_enable,
  output logic                       out_buzzer,
  output logic [6:0]                 out_shot_value,
  output logic [6:0]                 out_minutes_value,
  output logic [5:0]                 out_seconds_value,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic       in_acc, out_pop;
  clk_state_t st, st_nxt;
  result_t    res;
  result_t    head_r, tail_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign in_stall  = (cnt_r == 2'd2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_pop   = out_valid && !out_stall;

  scgcd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .accept      (in_acc),
    .kind        (in_kind),
    .press_long  (in_press_long),
    .press_short (in_press_short),
    .st          (st),
    .st_nxt      (st_nxt)
  );

  // The result reflects the clock state after this item's update.
  scgcd_disp u_disp (
    .st  (st_nxt),
    .res (res)
  );

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, in_acc} - {1'b0, out_pop};
  end

  // Head entry drives the ports; the tail entry holds a second result while
  // the head is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (cnt_r == 2'd2) begin
      if (out_pop) begin
        head_r <= tail_r;
      end
    end else if (cnt_r == 2'd1 && !out_pop) begin
      if (in_acc) begin
        tail_r <= res;
      end
    end else if (in_acc) begin
      head_r <= res;
    end
  end

  assign out_shot_segments     = head_r.shot_segments;
  assign out_shot_digit_enable = head_r.shot_digit_enable;
  assign out_game_segments     = head_r.game_segments;
  assign out_game_digit_enable = head_r.game_digit_enable;
  assign out_buzzer            = head_r.buzzer;
  assign out_shot_value        = head_r.shot_value;
  assign out_minutes_value     = head_r.minutes_value;
  assign out_seconds_value     = head_r.seconds_value;

  // A full queue whose head is stalled stays full.
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && out_stall) |=> (cnt_r == 2'd2))
    else $error("result queue changed while full and stalled");

  // A scan tick advances the digit phase by one.
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_kind && !cfg_we) |=> (st.phase == $past(st.phase) + 2'd1))
    else $error("scan tick did not advance the digit phase");

  // A second tick with a button pressed clears the expired state.
  a_button_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind && (in_press_long || in_press_short)) |=> !st.expired)
    else $error("button press did not clear the expired state");

  // The last result leaves and nothing new arrives: the output goes idle.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1 && out_pop && !in_acc) |=> !out_valid)
    else $error("output stayed valid after the last result left");

endmodule
`default_nettype wire
